### rtl/kbd_taps_pkg.sv
// shared types and constants for the keyboard report and scroll tap block
`default_nettype none

package kbd_taps_pkg;

  localparam int KEYS_PER_REPORT = 6;
  localparam int TAP_LIMIT       = 8;

  localparam int MAX_SLOTS  = 6;
  localparam int SLOTS      = (KEYS_PER_REPORT < MAX_SLOTS) ? KEYS_PER_REPORT : MAX_SLOTS;
  localparam int CODE_W     = 8;
  localparam int KEYS_W     = MAX_SLOTS * CODE_W;
  localparam int COUNT_W    = 3;
  localparam int TAP_W      = 5;

  localparam logic [7:0] OPT_MOD_BIT = 8'h08;
  localparam logic [7:0] KEY_PAGE_UP   = 8'h4B;
  localparam logic [7:0] KEY_PAGE_DOWN = 8'h4E;

  typedef struct packed {
    logic                   tick;
    logic signed [7:0]      scroll_delta;
    logic                   link_up;
    logic                   fn_held;
    logic                   opt_held;
    logic [7:0]             modifier_bits;
    logic [COUNT_W-1:0]     key_count;
    logic [KEYS_W-1:0]      key_codes;
  } scan_t;

  typedef struct packed {
    logic [7:0]        report_modifiers;
    logic [KEYS_W-1:0] report_keys;
  } report_t;

  // tap key that is held after the current scan
  typedef struct packed {
    logic              active;
    logic [CODE_W-1:0] code;
  } tap_t;

endpackage

`default_nettype wire

### rtl/kbd_taps_tap.sv
// scroll accumulator and page tap sequencer
`default_nettype none

module kbd_taps_tap (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire kbd_taps_pkg::scan_t scan,
  output kbd_taps_pkg::tap_t       tap
);
  import kbd_taps_pkg::*;

  localparam logic signed [8:0] LIM_POS = 9'(TAP_LIMIT);
  localparam logic signed [8:0] LIM_NEG = -9'(TAP_LIMIT);

  logic signed [TAP_W-1:0] pending_r, pending_nxt;
  logic                    active_r,  active_nxt;
  logic [CODE_W-1:0]       code_r,    code_nxt;
  logic signed [8:0]       sum;
  logic signed [TAP_W-1:0] sat;

  always_comb begin
    sum = 9'(pending_r) + 9'(scan.scroll_delta);
    if (sum > LIM_POS) begin
      sat = TAP_W'(LIM_POS);
    end else if (sum < LIM_NEG) begin
      sat = TAP_W'(LIM_NEG);
    end else begin
      sat = TAP_W'(sum);
    end

    pending_nxt = sat;
    active_nxt  = active_r;
    code_nxt    = code_r;
    // link down drops pending taps and the held tap before the tick is looked at
    if (!scan.link_up) begin
      pending_nxt = '0;
      active_nxt  = 1'b0;
    end
    if (scan.tick) begin
      if (active_nxt) begin
        active_nxt = 1'b0;
      end else if (pending_nxt != '0) begin
        active_nxt = 1'b1;
        if (pending_nxt > 0) begin
          code_nxt    = KEY_PAGE_DOWN;
          pending_nxt = pending_nxt - TAP_W'(1);
        end else begin
          code_nxt    = KEY_PAGE_UP;
          pending_nxt = pending_nxt + TAP_W'(1);
        end
      end
    end
  end

  assign tap.active = active_nxt;
  assign tap.code   = code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      active_r  <= 1'b0;
      code_r    <= '0;
    end else if (step) begin
      pending_r <= pending_nxt;
      active_r  <= active_nxt;
      code_r    <= code_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/kbd_taps_keys.sv
// fn remap and key slot builder
`default_nettype none

module kbd_taps_keys (
  input  wire kbd_taps_pkg::scan_t   scan,
  input  wire kbd_taps_pkg::tap_t    tap,
  output kbd_taps_pkg::report_t      report
);
  import kbd_taps_pkg::*;

  function automatic logic [CODE_W-1:0] remap_fn(input logic [CODE_W-1:0] k);
    logic [CODE_W-1:0] r;
    r = k;
    if (k >= 8'h1E && k <= 8'h27) begin
      r = 8'h3A + (k - 8'h1E);
    end else begin
      case (k)
        8'h2D:   r = 8'h44;  // minus to f11
        8'h2E:   r = 8'h45;  // equal to f12
        8'h33:   r = 8'h52;  // up
        8'h37:   r = 8'h51;  // down
        8'h36:   r = 8'h50;  // left
        8'h38:   r = 8'h4F;  // right
        default: r = k;
      endcase
    end
    return r;
  endfunction

  logic [COUNT_W-1:0] count;
  logic [CODE_W-1:0]  k;
  logic [KEYS_W-1:0]  keys;

  always_comb begin
    count = (32'(scan.key_count) > SLOTS) ? COUNT_W'(SLOTS) : scan.key_count;
    keys  = '0;
    for (int n = 0; n < MAX_SLOTS; n++) begin
      k = scan.key_codes[n*CODE_W +: CODE_W];
      if (scan.fn_held) begin
        k = remap_fn(k);
      end
      if (n < SLOTS) begin
        if (COUNT_W'(n) < count) begin
          keys[n*CODE_W +: CODE_W] = k;
        end else if (COUNT_W'(n) == count && tap.active) begin
          keys[n*CODE_W +: CODE_W] = tap.code;
        end
      end
    end
    report.report_keys      = keys;
    report.report_modifiers = scan.modifier_bits | (scan.opt_held ? OPT_MOD_BIT : 8'h00);
  end

endmodule

`default_nettype wire

### rtl/keyboard_report_scroll_taps_top.sv
// top level: scan register, report build, change filter and report register
//
//  channel | direction | payload              | handshake
//  in_     | in        | scan_t (one scan)    | in_valid / in_stall
//  out_    | out       | report_t (6-key)     | out_valid / out_stall
//
// one scan request is taken every cycle while the report side keeps up
// a taken scan sits in the scan register; its report, if any, is loaded
// into the report register once it can take a result, raising out_valid
// scans that leave modifiers and keys unchanged produce no report
// a held report freezes a waiting scan and raises in_stall; an empty scan
// register still takes a new scan
// synchronous active-low reset clears tap state, last report and valids
`default_nettype none

module keyboard_report_scroll_taps_top (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire kbd_taps_pkg::scan_t   in_data,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output kbd_taps_pkg::report_t      out_data
);
  import kbd_taps_pkg::*;

  logic    scan_vld_r;
  scan_t   scan_r;
  logic    out_vld_r;
  report_t out_r;
  logic [7:0]        prev_mods_r;
  logic [KEYS_W-1:0] prev_keys_r;

  tap_t    tap;
  report_t report;
  logic    advance;
  logic    changed;
  logic    emit;

  // scan in the register moves on once the report register can take a result
  assign advance  = scan_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = scan_vld_r && !advance;

  kbd_taps_tap u_tap (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .scan  (scan_r),
    .tap   (tap)
  );

  kbd_taps_keys u_keys (
    .scan   (scan_r),
    .tap    (tap),
    .report (report)
  );

  // only changed reports go out
  assign changed = (report.report_modifiers != prev_mods_r) ||
                   (report.report_keys != prev_keys_r);
  assign emit    = advance && changed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
      prev_mods_r <= '0;
      prev_keys_r <= '0;
    end else begin
      if (!in_stall) begin
        scan_vld_r <= in_valid;
      end
      if (emit) begin
        out_vld_r   <= 1'b1;
        prev_mods_r <= report.report_modifiers;
        prev_keys_r <= report.report_keys;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      scan_r <= in_data;
    end
    if (emit) begin
      out_r <= report;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the keyboard report builder with scroll-to-page taps
module tb_top;
  import kbd_taps_pkg::*;

  // run length and end-of-run timing
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_SCANS = 1430;
  localparam int DRAIN_CYCLES = 8;
  localparam int PAUSE_AT     = 700;

  // hid usage codes touched by the fn layer
  localparam logic [7:0] KEY_1         = 8'h1E;
  localparam logic [7:0] KEY_0         = 8'h27;
  localparam logic [7:0] KEY_F1        = 8'h3A;
  localparam logic [7:0] KEY_MINUS     = 8'h2D;
  localparam logic [7:0] KEY_EQUAL     = 8'h2E;
  localparam logic [7:0] KEY_F11       = 8'h44;
  localparam logic [7:0] KEY_F12       = 8'h45;
  localparam logic [7:0] KEY_SEMICOLON = 8'h33;
  localparam logic [7:0] KEY_PERIOD    = 8'h37;
  localparam logic [7:0] KEY_COMMA     = 8'h36;
  localparam logic [7:0] KEY_SLASH     = 8'h38;
  localparam logic [7:0] KEY_UP        = 8'h52;
  localparam logic [7:0] KEY_DOWN      = 8'h51;
  localparam logic [7:0] KEY_LEFT      = 8'h50;
  localparam logic [7:0] KEY_RIGHT     = 8'h4F;

  // punctuation keys that the fn layer remaps
  localparam logic [7:0] FN_PUNCT [6] = '{KEY_MINUS, KEY_EQUAL, KEY_SEMICOLON,
                                          KEY_PERIOD, KEY_COMMA, KEY_SLASH};

  // how a directed row gets its expected report
  typedef enum {ROW_PREDICT, ROW_NO_REPORT, ROW_REPORT} row_kind_t;

  typedef struct {
    scan_t     scan;
    row_kind_t kind;
    report_t   want;
  } scan_row_t;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  scan_t   in_data   = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  report_t out_data;

  // shadow copy of the block state
  int                taps_owed = 0;
  bit                tap_down  = 1'b0;
  logic [7:0]        tap_key   = 8'h00;
  logic [7:0]        last_mods = 8'h00;
  logic [KEYS_W-1:0] last_keys = '0;

  // reports owed by the block, oldest first
  report_t due_reports[$];
  report_t head;

  int mismatches = 0;
  int cycles     = 0;
  // window with no idling on either side
  bit calm       = 1'b0;

  keyboard_report_scroll_taps_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 8-unit clock period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // fn layer: digits, minus and equal to f-keys, punctuation to arrows
  function automatic logic [7:0] fn_layer(input logic [7:0] k);
    if (k >= KEY_1 && k <= KEY_0) return KEY_F1 + (k - KEY_1);
    case (k)
      KEY_MINUS:     return KEY_F11;
      KEY_EQUAL:     return KEY_F12;
      KEY_SEMICOLON: return KEY_UP;
      KEY_PERIOD:    return KEY_DOWN;
      KEY_COMMA:     return KEY_LEFT;
      KEY_SLASH:     return KEY_RIGHT;
      default:       return k;
    endcase
  endfunction

  // advance the shadow state by one scan and build its report
  task automatic build_report(input scan_t s, output bit fresh, output report_t r);
    int                d;
    int                cnt;
    int                n;
    logic [7:0]        mods;
    logic [7:0]        k;
    logic [KEYS_W-1:0] keys;
    d = int'($signed(s.scroll_delta));
    if (d != 0) begin
      taps_owed += d;
      if (taps_owed > TAP_LIMIT) taps_owed = TAP_LIMIT;
      if (taps_owed < -TAP_LIMIT) taps_owed = -TAP_LIMIT;
    end
    // link down drops pending taps and the held tap key
    if (!s.link_up) begin
      taps_owed = 0;
      tap_down  = 1'b0;
    end
    // each tick either releases the held tap or presses the next one
    if (s.tick) begin
      if (tap_down) begin
        tap_down = 1'b0;
      end else if (taps_owed != 0) begin
        tap_down  = 1'b1;
        tap_key   = (taps_owed > 0) ? KEY_PAGE_DOWN : KEY_PAGE_UP;
        taps_owed += (taps_owed > 0) ? -1 : 1;
      end
    end
    mods = s.modifier_bits | (s.opt_held ? OPT_MOD_BIT : 8'h00);
    cnt  = (int'(s.key_count) > SLOTS) ? SLOTS : int'(s.key_count);
    keys = '0;
    for (n = 0; n < cnt; n++) begin
      k = s.key_codes[8*n +: 8];
      keys[8*n +: 8] = s.fn_held ? fn_layer(k) : k;
    end
    // tap key goes in the first free slot, dropped when all are taken
    if (tap_down && cnt < SLOTS) keys[8*cnt +: 8] = tap_key;
    fresh = (mods != last_mods) || (keys != last_keys);
    if (fresh) begin
      last_mods = mods;
      last_keys = keys;
    end
    r.report_modifiers = mods;
    r.report_keys      = keys;
  endtask

  function automatic scan_t scan_of(input bit tick, input int delta, input bit link,
                                    input bit fn, input bit opt, input logic [7:0] mods,
                                    input int cnt, input logic [KEYS_W-1:0] codes);
    scan_t s;
    s.tick          = tick;
    s.scroll_delta  = 8'(delta);
    s.link_up       = link;
    s.fn_held       = fn;
    s.opt_held      = opt;
    s.modifier_bits = mods;
    s.key_count     = 3'(cnt);
    s.key_codes     = codes;
    return s;
  endfunction

  function automatic scan_row_t mk_row(input scan_t s, input row_kind_t kind,
                                       input report_t want);
    scan_row_t rw;
    rw.scan = s;
    rw.kind = kind;
    rw.want = want;
    return rw;
  endfunction

  // drive one scan request at the falling edge and hold it until taken
  task automatic send_scan(input scan_t s, input row_kind_t kind, input report_t want);
    bit      fresh;
    report_t r;
    // random gaps on the request side
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // taken at this edge, so the shadow state moves now
    build_report(s, fresh, r);
    case (kind)
      ROW_PREDICT: if (fresh) due_reports.push_back(r);
      ROW_REPORT:  due_reports.push_back(want);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // random back-pressure on the report side
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 9);
  end

  // compare every report taken against the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        flag_mismatch($sformatf("report mods %h keys %h with none owed",
                                out_data.report_modifiers, out_data.report_keys));
      end else begin
        head = due_reports.pop_front();
        if (out_data.report_modifiers !== head.report_modifiers)
          flag_mismatch($sformatf("modifiers %h, want %h",
                                  out_data.report_modifiers, head.report_modifiers));
        if (out_data.report_keys !== head.report_keys)
          flag_mismatch($sformatf("keys %h, want %h",
                                  out_data.report_keys, head.report_keys));
      end
    end
  end

  initial begin
    scan_row_t rows[$];
    scan_t     held;
    scan_t     s;
    report_t   none;
    int        i;
    int        n;
    int        waited;
    none = '0;

    // nothing changed from reset: no report
    rows.push_back(mk_row(scan_of(0, 0, 1, 0, 0, 8'h00, 0, 48'h0), ROW_NO_REPORT, none));
    // all modifiers with opt
    rows.push_back(mk_row(scan_of(0, 0, 1, 0, 1, 8'hFF, 0, 48'h0), ROW_REPORT,
                          '{8'hFF, 48'h0}));
    // opt alone sets its modifier bit
    rows.push_back(mk_row(scan_of(0, 0, 1, 0, 1, 8'h00, 0, 48'h0), ROW_REPORT,
                          '{OPT_MOD_BIT, 48'h0}));
    // all slots full of the largest code
    rows.push_back(mk_row(scan_of(0, 0, 1, 0, 0, 8'h00, 6, 48'hFFFF_FFFF_FFFF), ROW_REPORT,
                          '{8'h00, 48'hFFFF_FFFF_FFFF}));
    // key count past the slot count acts as the slot count
    rows.push_back(mk_row(scan_of(0, 0, 1, 0, 0, 8'h00, 7, 48'h0605_0403_0201), ROW_REPORT,
                          '{8'h00, 48'h0605_0403_0201}));
    // zero code inside the count kept, slots past the count cleared
    rows.push_back(mk_row(scan_of(0, 0, 1, 0, 0, 8'h00, 3, 48'hAABB_CC00_1122), ROW_REPORT,
                          '{8'h00, 48'h0000_0000_1122}));
    // fn: digits 1 to 6 become f1 to f6
    rows.push_back(mk_row(scan_of(0, 0, 1, 1, 0, 8'h00, 6, 48'h2322_2120_1F1E), ROW_REPORT,
                          '{8'h00, 48'h3F3E_3D3C_3B3A}));
    // fn: 7 to 0, minus and equal become f7 to f12
    rows.push_back(mk_row(scan_of(0, 0, 1, 1, 0, 8'h00, 6, 48'h2E2D_2726_2524), ROW_REPORT,
                          '{8'h00, 48'h4544_4342_4140}));
    // fn: punctuation becomes arrows
    rows.push_back(mk_row(scan_of(0, 0, 1, 1, 0, 8'h00, 4, 48'h0000_3836_3733), ROW_REPORT,
                          '{8'h00, 48'h0000_4F50_5152}));
    // same keys without fn pass through
    rows.push_back(mk_row(scan_of(0, 0, 1, 0, 0, 8'h00, 4, 48'h0000_3836_3733), ROW_REPORT,
                          '{8'h00, 48'h0000_3836_3733}));
    // largest positive scroll saturates, then page down press and release
    rows.push_back(mk_row(scan_of(0, 127, 1, 0, 0, 8'h00, 0, 48'h0), ROW_PREDICT, none));
    rows.push_back(mk_row(scan_of(1, 0, 1, 0, 0, 8'h00, 0, 48'h0), ROW_PREDICT, none));
    rows.push_back(mk_row(scan_of(1, 0, 1, 0, 0, 8'h00, 0, 48'h0), ROW_PREDICT, none));
    // tap pressed with every slot taken is dropped
    rows.push_back(mk_row(scan_of(1, 0, 1, 0, 0, 8'h00, 6, 48'h0102_0304_0506),
                          ROW_PREDICT, none));
    // most negative scroll saturates the other way
    rows.push_back(mk_row(scan_of(1, -128, 1, 0, 0, 8'h00, 6, 48'h0102_0304_0506),
                          ROW_PREDICT, none));
    rows.push_back(mk_row(scan_of(1, 0, 1, 0, 0, 8'h00, 2, 48'h0000_0000_1516),
                          ROW_PREDICT, none));
    // link down clears the held tap and the count
    rows.push_back(mk_row(scan_of(1, 0, 0, 0, 0, 8'h00, 2, 48'h0000_0000_1516),
                          ROW_PREDICT, none));
    rows.push_back(mk_row(scan_of(0, 5, 0, 0, 0, 8'h00, 0, 48'h0), ROW_PREDICT, none));
    rows.push_back(mk_row(scan_of(1, 1, 1, 0, 0, 8'h00, 0, 48'h0), ROW_PREDICT, none));
    rows.push_back(mk_row(scan_of(0, 0, 1, 0, 0, 8'h80, 0, 48'h0), ROW_PREDICT, none));
    rows.push_back(mk_row(scan_of(0, 0, 1, 0, 0, 8'h80, 0, 48'h0), ROW_PREDICT, none));
    rows.push_back(mk_row(scan_of(1, -1, 1, 0, 0, 8'h80, 0, 48'h0), ROW_PREDICT, none));
    rows.push_back(mk_row(scan_of(1, 0, 1, 0, 0, 8'h80, 0, 48'h0), ROW_PREDICT, none));

    // synchronous reset held, then released at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (rows[i]) send_scan(rows[i].scan, rows[i].kind, rows[i].want);

    // random scans: mostly held keys with changing tick and scroll,
    // now and then a fresh set of keys and modifiers
    held = '0;
    for (i = 0; i < RANDOM_SCANS; i++) begin
      calm = (i >= 400 && i < 650);
      // let the report side empty out completely once
      if (i == PAUSE_AT) begin
        in_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      if ($urandom_range(99) < 35) begin
        held.fn_held       = 1'($urandom_range(1));
        held.opt_held      = 1'($urandom_range(1));
        held.modifier_bits = $urandom_range(1) ? 8'($urandom_range(255)) : 8'h00;
        held.key_count     = 3'($urandom_range(7));
        for (n = 0; n < MAX_SLOTS; n++) begin
          case ($urandom_range(9))
            0, 1, 2: held.key_codes[8*n +: 8] = 8'(KEY_1 + $urandom_range(9));
            3, 4:    held.key_codes[8*n +: 8] = FN_PUNCT[$urandom_range(5)];
            5:       held.key_codes[8*n +: 8] = 8'h00;
            default: held.key_codes[8*n +: 8] = 8'($urandom_range(255));
          endcase
        end
      end
      s         = held;
      s.tick    = 1'($urandom_range(1));
      s.link_up = ($urandom_range(99) < 93);
      n = $urandom_range(99);
      if (n < 60) s.scroll_delta = 8'h00;
      else if (n < 88) s.scroll_delta = 8'($urandom_range(6)) - 8'd3;
      else s.scroll_delta = 8'($urandom_range(255));
      send_scan(s, ROW_PREDICT, none);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // wait for the last reports, then keep watching for stray ones
    waited = 0;
    while (due_reports.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_reports.size() != 0)
      flag_mismatch($sformatf("%0d reports never arrived", due_reports.size()));

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
